@@ rtl/deq_pkg.sv @@
package deq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Operation codes of the func field.
    localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_PURGE   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    // Result status codes.
    localparam logic STATUS_EMITTED = 1'b0;
    localparam logic STATUS_FULL    = 1'b1;

    // One stored entry of the queue.
    typedef struct packed {
        logic [31:0] due;
        logic [15:0] thing_type;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] heading;
        logic [31:0] flags;
        logic        notify;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ rtl/deq_ram.sv @@
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/deferred_event_queue_unit.sv @@
// Deferred event queue. Requests are held in one entry memory, sorted by due
// time, as a circular buffer behind a head pointer. An immediate or full-queue
// enqueue waits in S_EMIT_NOW for the output register; a purge or an
// ignored code is done in S_IDLE. A stored enqueue searches backward from the
// tail, moving each later entry one place down: each step reads the entry
// ahead through the single registered read port (S_ENQ_RD), then compares and
// writes (S_ENQ_CMP); the new entry is written there, or in S_ENQ_RD at the
// head. A tick reads the head entries one by one (S_TICK_RD, S_TICK_CMP) and
// emits each due entry once the output register is free; emitted entries
// leave by moving the head pointer. One transaction is worked on at a time.
module deferred_event_queue_unit
    import deq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_delay_tics,
    input  logic [15:0] i_thing_type,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_heading,
    input  logic [31:0] i_spawn_flags,
    input  logic        i_notify_requested,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [15:0] o_out_type,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [31:0] o_out_heading,
    output logic [31:0] o_out_flags,
    output logic        o_notify,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT_NOW,
        S_ENQ_RD,
        S_ENQ_CMP,
        S_TICK_RD,
        S_TICK_CMP,
        S_TICK_LAST
    } t_state;

    typedef logic [CNT_W:0] t_sum;

    t_state             r_state;
    logic [31:0]        r_tick;
    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_full;
    logic               r_have;
    t_entry             r_req;
    t_entry             r_held;
    logic               r_out_valid;
    t_entry             r_out;
    logic               r_out_status;
    logic               r_out_last;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    t_entry             wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic [ENTRY_W-1:0] rdata_bits;
    t_entry             rdata;
    logic [31:0]        remain;
    logic               out_free;
    logic               in_fire;
    t_entry             new_entry;
    logic               out_load;

    // Physical slot of a logical queue position.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        t_sum s;
        s = t_sum'(head) + t_sum'(pos);
        if (s >= t_sum'(QUEUE_DEPTH)) begin
            s = s - t_sum'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    deq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata_bits)
    );

    assign rdata    = t_entry'(rdata_bits);
    assign remain   = rdata.due - r_tick;
    assign out_free = !r_out_valid || i_out_ready;
    assign in_fire  = i_in_valid && o_in_ready;

    // The output register takes a new transaction in these cases.
    assign out_load = out_free &&
                      ((r_state == S_EMIT_NOW) || (r_state == S_TICK_LAST) ||
                       (r_state == S_TICK_CMP && r_have &&
                        (remain[31] || remain == '0)));

    // A new entry is stored with its absolute due time.
    always_comb begin
        new_entry     = r_req;
        new_entry.due = r_tick + r_req.due;
    end

    // Memory port control for the insertion and tick walks.
    always_comb begin
        we    = 1'b0;
        waddr = phys(r_head, r_idx);
        wdata = new_entry;
        re    = 1'b0;
        raddr = phys(r_head, r_idx);
        unique case (r_state)
            S_ENQ_RD: begin
                if (r_idx == '0) begin
                    we = 1'b1;
                end else begin
                    re    = 1'b1;
                    raddr = phys(r_head, r_idx - CNT_W'(1));
                end
            end
            S_ENQ_CMP: begin
                we = 1'b1;
                if ($signed(remain) > $signed({16'd0, r_req.due[15:0]})) begin
                    wdata = rdata;
                end
            end
            S_TICK_RD: begin
                re = (r_idx != r_count);
            end
            default: begin
            end
        endcase
    end

    // Control sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_full      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        // The due field carries the raw delay until the entry is written.
                        r_req.due        <= {16'd0, i_delay_tics};
                        r_req.thing_type <= i_thing_type;
                        r_req.pos_x      <= i_pos_x;
                        r_req.pos_y      <= i_pos_y;
                        r_req.pos_z      <= i_pos_z;
                        r_req.heading    <= i_heading;
                        r_req.flags      <= i_spawn_flags;
                        r_req.notify     <= i_notify_requested;
                        r_idx            <= r_count;
                        r_have           <= 1'b0;
                        unique case (i_func)
                            FUNC_ENQUEUE: begin
                                if (i_delay_tics == '0) begin
                                    r_full  <= 1'b0;
                                    r_state <= S_EMIT_NOW;
                                end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                    r_full  <= 1'b1;
                                    r_state <= S_EMIT_NOW;
                                end else begin
                                    r_state <= S_ENQ_RD;
                                end
                            end
                            FUNC_TICK: begin
                                r_idx   <= '0;
                                r_state <= S_TICK_RD;
                            end
                            FUNC_PURGE: begin
                                r_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EMIT_NOW: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_last   <= 1'b1;
                        r_out_status <= r_full ? STATUS_FULL : STATUS_EMITTED;
                        r_out        <= r_full ? '0 : r_req;
                        r_state      <= S_IDLE;
                    end
                end
                S_ENQ_RD: begin
                    if (r_idx == '0) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ENQ_CMP;
                    end
                end
                S_ENQ_CMP: begin
                    if ($signed(remain) > $signed({16'd0, r_req.due[15:0]})) begin
                        r_idx   <= r_idx - CNT_W'(1);
                        r_state <= S_ENQ_RD;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_TICK_RD: begin
                    if (r_idx != r_count) begin
                        r_state <= S_TICK_CMP;
                    end else if (r_have) begin
                        r_state <= S_TICK_LAST;
                    end else begin
                        r_tick  <= r_tick + 32'd1;
                        r_state <= S_IDLE;
                    end
                end
                S_TICK_CMP: begin
                    if (remain[31] || remain == '0) begin
                        // A due entry: hold it, and pass any held one on, not as the last.
                        if (!r_have) begin
                            r_held  <= rdata;
                            r_have  <= 1'b1;
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_TICK_RD;
                        end else if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_last   <= 1'b0;
                            r_out_status <= STATUS_EMITTED;
                            r_out        <= r_held;
                            r_held       <= rdata;
                            r_idx        <= r_idx + CNT_W'(1);
                            r_state      <= S_TICK_RD;
                        end
                    end else if (r_have) begin
                        r_state <= S_TICK_LAST;
                    end else begin
                        r_tick  <= r_tick + 32'd1;
                        r_state <= S_IDLE;
                    end
                end
                S_TICK_LAST: begin
                    // Emit the final due entry and drop the emitted ones.
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_last   <= 1'b1;
                        r_out_status <= STATUS_EMITTED;
                        r_out        <= r_held;
                        r_head       <= phys(r_head, r_idx);
                        r_count      <= r_count - r_idx;
                        r_tick       <= r_tick + 32'd1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_type    = r_out.thing_type;
    assign o_out_x       = r_out.pos_x;
    assign o_out_y       = r_out.pos_y;
    assign o_out_z       = r_out.pos_z;
    assign o_out_heading = r_out.heading;
    assign o_out_flags   = r_out.flags;
    assign o_notify      = r_out.notify;
    assign o_last        = r_out_last;

endmodule
